// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked every clock outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication into the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// ----- rtl/sscs_pkg.sv -----
// types and codes of the start-up safety check sequencer
package sscs_pkg;

  localparam int unsigned PressW = 16;

  typedef enum logic [1:0] {
    CmdStart  = 2'd0,
    CmdExpiry = 2'd1,
    CmdReset  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TmrNone   = 2'd0,
    Tmr1ms    = 2'd1,
    Tmr1s     = 2'd2,
    TmrCancel = 2'd3
  } tmr_e;

  typedef enum logic [2:0] {
    ActNone     = 3'd0,
    ActWdogOn   = 3'd1,
    ActWdogOff  = 3'd2,
    ActEbsOn    = 3'd3,
    ActEbsOff   = 3'd4,
    ActTsWdogOn = 3'd5,
    ActResetAll = 3'd6
  } act_e;

  typedef enum logic [3:0] {
    WarnNone       = 4'd0,
    WarnMission    = 4'd1,
    WarnSwitch     = 4'd2,
    WarnWatchdog   = 4'd3,
    WarnOverPress  = 4'd4,
    WarnUnpress    = 4'd5,
    WarnHydLow     = 4'd6,
    WarnTsFail     = 4'd7,
    WarnReleaseHi  = 4'd8
  } warn_e;

  typedef enum logic [4:0] {
    StepIdle       = 5'd0,
    StepMission    = 5'd1,
    StepSwitch     = 5'd2,
    StepWdogOn     = 5'd3,
    StepWdogGood   = 5'd4,
    StepWdogOff    = 5'd5,
    StepPneumatic  = 5'd6,
    StepEbsOn      = 5'd7,
    StepHydEngaged = 5'd8,
    StepTsOn       = 5'd9,
    StepWait0      = 5'd10,
    StepWait1      = 5'd11,
    StepWait2      = 5'd12,
    StepWait3      = 5'd13,
    StepWait4      = 5'd14,
    StepWait5      = 5'd15,
    StepTsCheck    = 5'd16,
    StepEbsOff     = 5'd17,
    StepHydRelease = 5'd18,
    StepEbsAgain   = 5'd19,
    StepHydFinal   = 5'd20,
    StepSuccess    = 5'd21
  } step_e;

  typedef enum logic [1:0] {
    RegHydReleaseMax  = 2'd0,
    RegHydEngagedMin  = 2'd1,
    RegPneuOverPress  = 2'd2,
    RegPneuMinPress   = 2'd3
  } reg_e;

  localparam logic [PressW-1:0] HydReleaseMaxRst = 16'd300;
  localparam logic [PressW-1:0] HydEngagedMinRst = 16'd3000;
  localparam logic [PressW-1:0] PneuOverPressRst = 16'd1200;
  localparam logic [PressW-1:0] PneuMinPressRst  = 16'd400;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              mission_autonomous;
    logic              master_switch_on;
    logic              master_switch_confirmed;
    logic              watchdog_good;
    logic              ts_on;
    logic              battery_ts_active;
    logic [PressW-1:0] pneumatic_front;
    logic [PressW-1:0] pneumatic_rear;
    logic [PressW-1:0] hydraulic_front;
    logic [PressW-1:0] hydraulic_rear;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] timer_request;
    logic [2:0] actuator_command;
    logic [3:0] warning_code;
    logic       ebs_failure_led;
    logic       sequence_failed;
    logic       sequence_succeeded;
    logic       clear_brake_request;
    logic [4:0] current_step;
  } out_beat_t;

  typedef struct packed {
    logic [PressW-1:0] hydraulic_release_max;
    logic [PressW-1:0] hydraulic_engaged_min;
    logic [PressW-1:0] pneumatic_overpressure;
    logic [PressW-1:0] pneumatic_min_pressure;
  } cfg_t;

endpackage

// ----- rtl/startup_safety_check_sequencer.sv -----
// top level of the start-up safety check sequencer
//
//  channel  | signals                         | direction | payload
//  ---------+---------------------------------+-----------+-----------------------
//  in       | in_valid_i / in_ready_o         | in        | in_beat_i  (in_beat_t)
//  out      | out_valid_o / out_ready_i       | out       | out_beat_o (out_beat_t)
//  cfg      | cfg_valid_i / cfg_ready_o       | in        | cfg_index_i, cfg_data_i
//
//  one event per cycle sustained while out_ready_i stays high; an accepted event passes
//  through the input register, then the decision logic into the result register
//  the step register moves with each event into the result register, so the next event sees it
//  a stalled result holds the input register; ready then follows out_ready_i
//  reset puts the sequence in the idle step and loads the default thresholds
//  cfg writes are always taken; cfg_ready_o is tied high
module startup_safety_check_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  sscs_pkg::in_beat_t          in_beat_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sscs_pkg::out_beat_t         out_beat_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [sscs_pkg::PressW-1:0] cfg_data_i
);

`include "assert_macros.svh"

  sscs_pkg::cfg_t      cfg;
  sscs_pkg::in_beat_t  in_q;
  logic                in_valid_q;
  sscs_pkg::out_beat_t out_q, out_d;
  logic                out_valid_q;
  sscs_pkg::step_e     step_q, step_d;
  logic                advance;

  // threshold registers
  sscs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // decision logic between the input and result registers
  sscs_step u_step (
    .step_i (step_q),
    .beat_i (in_q),
    .cfg_i  (cfg),
    .step_o (step_d),
    .beat_o (out_d)
  );

  // event moves forward when the result slot is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= sscs_pkg::StepIdle;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        step_q      <= step_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_beat_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // the step never leaves the defined range
  `ASSERT_ALWAYS(a_step_range, clk_i, rst_ni, step_q <= sscs_pkg::StepSuccess)
  // a reset event always lands in the idle step
  `ASSERT_NEXT(a_reset_idle, clk_i, rst_ni, advance && (in_q.cmd == sscs_pkg::CmdReset), step_q == sscs_pkg::StepIdle)
  // a failure pulse always carries a warning code
  `ASSERT_ALWAYS(a_fail_warn, clk_i, rst_ni, !(out_valid_q && out_q.sequence_failed) || (out_q.warning_code != sscs_pkg::WarnNone))
  // success only reported from the success step
  `ASSERT_ALWAYS(a_success_step, clk_i, rst_ni, !(out_valid_q && out_q.sequence_succeeded) || (out_q.current_step == sscs_pkg::StepSuccess))

endmodule

// ----- rtl/sscs_cfg.sv -----
// threshold register file written through the config channel
module sscs_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [sscs_pkg::PressW-1:0]  cfg_data_i,
  output sscs_pkg::cfg_t               cfg_o
);

  sscs_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hydraulic_release_max  <= sscs_pkg::HydReleaseMaxRst;
      cfg_q.hydraulic_engaged_min  <= sscs_pkg::HydEngagedMinRst;
      cfg_q.pneumatic_overpressure <= sscs_pkg::PneuOverPressRst;
      cfg_q.pneumatic_min_pressure <= sscs_pkg::PneuMinPressRst;
    end else if (cfg_valid_i) begin
      case (sscs_pkg::reg_e'(cfg_index_i))
        sscs_pkg::RegHydReleaseMax: cfg_q.hydraulic_release_max  <= cfg_data_i;
        sscs_pkg::RegHydEngagedMin: cfg_q.hydraulic_engaged_min  <= cfg_data_i;
        sscs_pkg::RegPneuOverPress: cfg_q.pneumatic_overpressure <= cfg_data_i;
        sscs_pkg::RegPneuMinPress:  cfg_q.pneumatic_min_pressure <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/sscs_step.sv -----
// per-event decision: checks of the current step, next step and result fields
module sscs_step (
  input  sscs_pkg::step_e    step_i,
  input  sscs_pkg::in_beat_t beat_i,
  input  sscs_pkg::cfg_t     cfg_i,
  output sscs_pkg::step_e    step_o,
  output sscs_pkg::out_beat_t beat_o
);

  logic pneu_over, pneu_under, hyd_low, hyd_high;
  logic adv, fail, fled;
  sscs_pkg::tmr_e  tmr, nxt_tmr;
  sscs_pkg::act_e  act;
  sscs_pkg::warn_e fw;
  sscs_pkg::step_e step_n;
  logic clr, ok;

  // max above limit / min below limit, per pair of sensors
  assign pneu_over  = (beat_i.pneumatic_front > cfg_i.pneumatic_overpressure) ||
                      (beat_i.pneumatic_rear  > cfg_i.pneumatic_overpressure);
  assign pneu_under = (beat_i.pneumatic_front < cfg_i.pneumatic_min_pressure) ||
                      (beat_i.pneumatic_rear  < cfg_i.pneumatic_min_pressure);
  assign hyd_low    = (beat_i.hydraulic_front < cfg_i.hydraulic_engaged_min) ||
                      (beat_i.hydraulic_rear  < cfg_i.hydraulic_engaged_min);
  assign hyd_high   = (beat_i.hydraulic_front > cfg_i.hydraulic_release_max) ||
                      (beat_i.hydraulic_rear  > cfg_i.hydraulic_release_max);

  always_comb begin
    adv     = 1'b0;
    fail    = 1'b0;
    fled    = 1'b0;
    nxt_tmr = sscs_pkg::TmrNone;
    fw      = sscs_pkg::WarnNone;
    act     = sscs_pkg::ActNone;
    case (step_i)
      sscs_pkg::StepMission: begin
        if (beat_i.mission_autonomous) begin
          adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1ms;
        end else begin
          fail = 1'b1; fw = sscs_pkg::WarnMission;
        end
      end
      sscs_pkg::StepSwitch: begin
        if (beat_i.master_switch_on && beat_i.master_switch_confirmed) begin
          adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1ms;
        end else begin
          fail = 1'b1; fw = sscs_pkg::WarnSwitch;
        end
      end
      sscs_pkg::StepWdogOn: begin
        act = sscs_pkg::ActWdogOn; adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1s;
      end
      sscs_pkg::StepWdogGood: begin
        if (beat_i.watchdog_good) begin
          act = sscs_pkg::ActWdogOff; adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1s;
        end else begin
          fail = 1'b1; fw = sscs_pkg::WarnWatchdog;
        end
      end
      sscs_pkg::StepWdogOff: begin
        if (!beat_i.watchdog_good) begin
          adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1ms;
        end else begin
          fail = 1'b1; fw = sscs_pkg::WarnWatchdog;
        end
      end
      sscs_pkg::StepPneumatic: begin
        // a pass only cancels the timer and waits for the second start
        if (pneu_over) begin
          fail = 1'b1; fw = sscs_pkg::WarnOverPress; fled = 1'b1;
        end else if (pneu_under) begin
          fail = 1'b1; fw = sscs_pkg::WarnUnpress; fled = 1'b1;
        end
      end
      sscs_pkg::StepEbsOn, sscs_pkg::StepEbsAgain: begin
        act = sscs_pkg::ActEbsOn; adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1s;
      end
      sscs_pkg::StepHydEngaged: begin
        if (hyd_low) begin
          fail = 1'b1; fw = sscs_pkg::WarnHydLow; fled = 1'b1;
        end else begin
          adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1ms;
        end
      end
      sscs_pkg::StepTsOn: begin
        act = sscs_pkg::ActTsWdogOn; adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1s;
      end
      sscs_pkg::StepWait0, sscs_pkg::StepWait1, sscs_pkg::StepWait2,
      sscs_pkg::StepWait3, sscs_pkg::StepWait4, sscs_pkg::StepWait5: begin
        adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1s;
      end
      sscs_pkg::StepTsCheck: begin
        if (beat_i.ts_on && beat_i.battery_ts_active) begin
          adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1ms;
        end else begin
          fail = 1'b1; fw = sscs_pkg::WarnTsFail;
        end
      end
      sscs_pkg::StepEbsOff: begin
        act = sscs_pkg::ActEbsOff; adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1s;
      end
      sscs_pkg::StepHydRelease: begin
        if (hyd_high) begin
          fail = 1'b1; fw = sscs_pkg::WarnReleaseHi; fled = 1'b1;
        end else begin
          adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1ms;
        end
      end
      sscs_pkg::StepHydFinal: begin
        if (hyd_low) begin
          fail = 1'b1; fw = sscs_pkg::WarnHydLow; fled = 1'b1;
        end else begin
          adv = 1'b1; nxt_tmr = sscs_pkg::Tmr1s;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    step_n = step_i;
    tmr    = sscs_pkg::TmrNone;
    clr    = 1'b0;
    ok     = 1'b0;
    beat_o = '0;
    case (sscs_pkg::cmd_e'(beat_i.cmd))
      sscs_pkg::CmdStart: begin
        if (step_i == sscs_pkg::StepIdle) begin
          clr = 1'b1; step_n = sscs_pkg::StepMission; tmr = sscs_pkg::Tmr1ms;
        end else if (step_i == sscs_pkg::StepPneumatic) begin
          step_n = sscs_pkg::StepEbsOn; tmr = sscs_pkg::Tmr1ms;
        end
      end
      sscs_pkg::CmdReset: begin
        tmr = sscs_pkg::TmrCancel;
        step_n = sscs_pkg::StepIdle;
        beat_o.actuator_command = sscs_pkg::ActResetAll;
      end
      sscs_pkg::CmdExpiry: begin
        tmr = sscs_pkg::TmrCancel;
        ok  = (step_i == sscs_pkg::StepSuccess);
        beat_o.actuator_command = act;
        if (adv) begin
          step_n = sscs_pkg::step_e'(step_i + 5'd1);
          tmr    = nxt_tmr;
        end else if (fail) begin
          beat_o.sequence_failed = 1'b1;
          beat_o.warning_code    = fw;
          beat_o.ebs_failure_led = fled;
        end
      end
      default: ;
    endcase
    beat_o.timer_request       = tmr;
    beat_o.clear_brake_request = clr;
    beat_o.sequence_succeeded  = ok;
    beat_o.current_step        = step_n;
  end

  assign step_o = step_n;

endmodule

// ----- tb/tb_startup_safety_check_sequencer.sv -----
// self-checking testbench for the start-up safety check sequencer
`timescale 1ns / 1ps

module tb_startup_safety_check_sequencer;

  localparam int ClkPeriod     = 8;
  localparam int ResetCycles   = 9;
  localparam int SettleCycles  = 8;       // a little beyond the input and result registers
  localparam int HoldOffCycles = 200;     // long receiver stall for the fill-up test
  localparam int CycleLimit    = 300000;
  localparam int MaxReports    = 40;

  // ---------------------------------------------------------------------------
  // clock, reset and dut signals
  // ---------------------------------------------------------------------------
  logic                        clk = 1'b0;
  logic                        rst_ni;
  logic                        in_valid;
  logic                        in_ready;
  sscs_pkg::in_beat_t          in_beat;
  logic                        out_valid;
  logic                        out_ready;
  sscs_pkg::out_beat_t         out_beat;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [1:0]                  cfg_index;
  logic [sscs_pkg::PressW-1:0] cfg_data;

  always #(ClkPeriod / 2) clk = ~clk;

  startup_safety_check_sequencer uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // shadow state of the sequencer, advanced at every accepted event beat
  // ---------------------------------------------------------------------------
  logic [4:0]          seq_step;
  sscs_pkg::cfg_t      thresholds;
  sscs_pkg::out_beat_t pending_outcomes[$];   // predicted result beats, oldest first

  int          in_idle_pct  = 30;     // chance in percent that the sender idles
  int          out_idle_pct = 30;     // chance in percent that the receiver stalls
  int          hold_offs_asked  = 0;  // written by the test sequence only
  int          hold_offs_served = 0;  // written by the receiver only
  int          mismatch_count = 0;
  int          results_seen   = 0;
  int unsigned cycle_count    = 0;

  task automatic report_mismatch(string msg);
    if (mismatch_count < MaxReports) $display("[%0t] result %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  // outcome of one event; updates the shadow step like the block does
  function automatic sscs_pkg::out_beat_t predict_outcome(sscs_pkg::in_beat_t ev);
    sscs_pkg::out_beat_t r;
    sscs_pkg::tmr_e      next_tmr;
    sscs_pkg::warn_e     warn;
    logic [15:0]         pneu_hi, pneu_lo, hyd_hi, hyd_lo;
    r        = '0;
    next_tmr = sscs_pkg::TmrNone;
    warn     = sscs_pkg::WarnNone;
    pneu_hi  = (ev.pneumatic_front > ev.pneumatic_rear) ? ev.pneumatic_front : ev.pneumatic_rear;
    pneu_lo  = (ev.pneumatic_front < ev.pneumatic_rear) ? ev.pneumatic_front : ev.pneumatic_rear;
    hyd_hi   = (ev.hydraulic_front > ev.hydraulic_rear) ? ev.hydraulic_front : ev.hydraulic_rear;
    hyd_lo   = (ev.hydraulic_front < ev.hydraulic_rear) ? ev.hydraulic_front : ev.hydraulic_rear;
    case (ev.cmd)
      sscs_pkg::CmdStart: begin
        // only idle and the pneumatic step react to a start
        if (seq_step == sscs_pkg::StepIdle) begin
          r.clear_brake_request = 1'b1;
          r.timer_request       = sscs_pkg::Tmr1ms;
          seq_step              = sscs_pkg::StepMission;
        end else if (seq_step == sscs_pkg::StepPneumatic) begin
          r.timer_request = sscs_pkg::Tmr1ms;
          seq_step        = sscs_pkg::StepEbsOn;
        end
      end
      sscs_pkg::CmdReset: begin
        r.timer_request    = sscs_pkg::TmrCancel;
        r.actuator_command = sscs_pkg::ActResetAll;
        seq_step           = sscs_pkg::StepIdle;
      end
      sscs_pkg::CmdExpiry: begin
        r.timer_request = sscs_pkg::TmrCancel;
        case (seq_step)
          sscs_pkg::StepMission:
            if (ev.mission_autonomous) next_tmr = sscs_pkg::Tmr1ms;
            else warn = sscs_pkg::WarnMission;
          sscs_pkg::StepSwitch:
            if (ev.master_switch_on && ev.master_switch_confirmed) next_tmr = sscs_pkg::Tmr1ms;
            else warn = sscs_pkg::WarnSwitch;
          sscs_pkg::StepWdogOn: begin
            r.actuator_command = sscs_pkg::ActWdogOn;
            next_tmr           = sscs_pkg::Tmr1s;
          end
          sscs_pkg::StepWdogGood:
            if (ev.watchdog_good) begin
              r.actuator_command = sscs_pkg::ActWdogOff;
              next_tmr           = sscs_pkg::Tmr1s;
            end else warn = sscs_pkg::WarnWatchdog;
          sscs_pkg::StepWdogOff:
            if (!ev.watchdog_good) next_tmr = sscs_pkg::Tmr1ms;
            else warn = sscs_pkg::WarnWatchdog;
          // a passed pneumatic check just waits for the second start
          sscs_pkg::StepPneumatic:
            if (pneu_hi > thresholds.pneumatic_overpressure) warn = sscs_pkg::WarnOverPress;
            else if (pneu_lo < thresholds.pneumatic_min_pressure) warn = sscs_pkg::WarnUnpress;
          sscs_pkg::StepEbsOn, sscs_pkg::StepEbsAgain: begin
            r.actuator_command = sscs_pkg::ActEbsOn;
            next_tmr           = sscs_pkg::Tmr1s;
          end
          sscs_pkg::StepHydEngaged, sscs_pkg::StepHydFinal:
            if (hyd_lo < thresholds.hydraulic_engaged_min) warn = sscs_pkg::WarnHydLow;
            else next_tmr = (seq_step == sscs_pkg::StepHydEngaged) ? sscs_pkg::Tmr1ms
                                                                     : sscs_pkg::Tmr1s;
          sscs_pkg::StepTsOn: begin
            r.actuator_command = sscs_pkg::ActTsWdogOn;
            next_tmr           = sscs_pkg::Tmr1s;
          end
          sscs_pkg::StepWait0, sscs_pkg::StepWait1, sscs_pkg::StepWait2,
          sscs_pkg::StepWait3, sscs_pkg::StepWait4, sscs_pkg::StepWait5:
            next_tmr = sscs_pkg::Tmr1s;
          sscs_pkg::StepTsCheck:
            if (ev.ts_on && ev.battery_ts_active) next_tmr = sscs_pkg::Tmr1ms;
            else warn = sscs_pkg::WarnTsFail;
          sscs_pkg::StepEbsOff: begin
            r.actuator_command = sscs_pkg::ActEbsOff;
            next_tmr           = sscs_pkg::Tmr1s;
          end
          sscs_pkg::StepHydRelease:
            if (hyd_hi > thresholds.hydraulic_release_max) warn = sscs_pkg::WarnReleaseHi;
            else next_tmr = sscs_pkg::Tmr1ms;
          sscs_pkg::StepSuccess:
            r.sequence_succeeded = 1'b1;
          default: ;
        endcase
        // every advance restarts the timer; every failure carries a warning
        if (next_tmr != sscs_pkg::TmrNone) begin
          seq_step        = seq_step + 5'd1;
          r.timer_request = next_tmr;
        end else if (warn != sscs_pkg::WarnNone) begin
          r.sequence_failed = 1'b1;
          r.warning_code    = warn;
          r.ebs_failure_led = (warn == sscs_pkg::WarnOverPress) ||
                              (warn == sscs_pkg::WarnUnpress) ||
                              (warn == sscs_pkg::WarnHydLow) ||
                              (warn == sscs_pkg::WarnReleaseHi);
        end
      end
      default: ;  // unknown command leaves everything alone
    endcase
    r.current_step = seq_step;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // pressure biased toward the rails and toward the edges of a threshold
  function automatic logic [15:0] rand_press();
    logic [15:0] near;
    case ($urandom_range(3))
      0:       near = thresholds.hydraulic_release_max;
      1:       near = thresholds.hydraulic_engaged_min;
      2:       near = thresholds.pneumatic_overpressure;
      default: near = thresholds.pneumatic_min_pressure;
    endcase
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return near + 16'($urandom_range(2)) - 16'd1;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // event with random content; with meet_checks the readings satisfy the
  // check of the current step whenever the thresholds allow it
  function automatic sscs_pkg::in_beat_t make_event(sscs_pkg::cmd_e c, bit meet_checks);
    sscs_pkg::in_beat_t ev;
    ev.cmd                     = c;
    ev.mission_autonomous      = 1'($urandom_range(1));
    ev.master_switch_on        = 1'($urandom_range(1));
    ev.master_switch_confirmed = 1'($urandom_range(1));
    ev.watchdog_good           = 1'($urandom_range(1));
    ev.ts_on                   = 1'($urandom_range(1));
    ev.battery_ts_active       = 1'($urandom_range(1));
    ev.pneumatic_front         = rand_press();
    ev.pneumatic_rear          = rand_press();
    ev.hydraulic_front         = rand_press();
    ev.hydraulic_rear          = rand_press();
    if (meet_checks) begin
      ev.mission_autonomous      = 1'b1;
      ev.master_switch_on        = 1'b1;
      ev.master_switch_confirmed = 1'b1;
      ev.ts_on                   = 1'b1;
      ev.battery_ts_active       = 1'b1;
      // watchdog must read good while on and drop once it is switched off
      ev.watchdog_good           = (seq_step == sscs_pkg::StepWdogGood);
      if (thresholds.pneumatic_min_pressure <= thresholds.pneumatic_overpressure) begin
        ev.pneumatic_front = 16'($urandom_range(thresholds.pneumatic_overpressure,
                                                thresholds.pneumatic_min_pressure));
        ev.pneumatic_rear  = 16'($urandom_range(thresholds.pneumatic_overpressure,
                                                thresholds.pneumatic_min_pressure));
      end
      if (seq_step == sscs_pkg::StepHydRelease) begin
        ev.hydraulic_front = 16'($urandom_range(thresholds.hydraulic_release_max, 0));
        ev.hydraulic_rear  = 16'($urandom_range(thresholds.hydraulic_release_max, 0));
      end else begin
        ev.hydraulic_front = 16'($urandom_range(65535, thresholds.hydraulic_engaged_min));
        ev.hydraulic_rear  = 16'($urandom_range(65535, thresholds.hydraulic_engaged_min));
      end
    end
    return ev;
  endfunction

  // mostly well-formed walks through the sequence, with some failing
  // readings, stray starts, resets and unknown commands mixed in
  function automatic sscs_pkg::in_beat_t random_event();
    int             pick;
    sscs_pkg::cmd_e c;
    pick = int'($urandom_range(99));
    if (pick < 3) c = sscs_pkg::CmdReset;
    else if (pick < 6) c = sscs_pkg::CmdNone;
    else if (seq_step == sscs_pkg::StepIdle || seq_step == sscs_pkg::StepPneumatic)
      c = (pick < 55) ? sscs_pkg::CmdStart : sscs_pkg::CmdExpiry;
    else if (seq_step == sscs_pkg::StepSuccess)
      c = (pick < 40) ? sscs_pkg::CmdReset : sscs_pkg::CmdExpiry;
    else c = (pick < 10) ? sscs_pkg::CmdStart : sscs_pkg::CmdExpiry;
    return make_event(c, $urandom_range(99) < 85);
  endfunction

  // offer one event beat; valid stays up until the beat is taken
  task automatic offer_event(sscs_pkg::in_beat_t ev);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= ev;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_outcomes.push_back(predict_outcome(ev));
  endtask

  // stop offering and let every predicted result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // write all four thresholds while the block is idle
  task automatic load_thresholds(sscs_pkg::cfg_t t);
    sscs_pkg::reg_e idx;
    logic [15:0]    val;
    for (int i = 0; i < 4; i++) begin
      idx = sscs_pkg::reg_e'(i);
      case (idx)
        sscs_pkg::RegHydReleaseMax: val = t.hydraulic_release_max;
        sscs_pkg::RegHydEngagedMin: val = t.hydraulic_engaged_min;
        sscs_pkg::RegPneuOverPress: val = t.pneumatic_overpressure;
        default:                    val = t.pneumatic_min_pressure;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid  <= 1'b0;
    thresholds  = t;
  endtask

  function automatic sscs_pkg::cfg_t plausible_thresholds();
    sscs_pkg::cfg_t t;
    t.hydraulic_release_max  = 16'($urandom_range(2000));
    t.hydraulic_engaged_min  = 16'($urandom_range(5000, 1000));
    t.pneumatic_overpressure = 16'($urandom_range(3000, 800));
    t.pneumatic_min_pressure = 16'($urandom_range(800, 100));
    return t;
  endfunction

  // walk forward with passing readings until the shadow step reaches target
  task automatic walk_to(logic [4:0] target);
    while (seq_step != target) offer_event(make_event(sscs_pkg::CmdExpiry, 1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // events that find the sequence idle: expiry only cancels, unknown is ignored, reset resets all
  task automatic test_idle_events();
    offer_event(make_event(sscs_pkg::CmdExpiry, 1'b0));
    offer_event(make_event(sscs_pkg::CmdNone, 1'b0));
    offer_event(make_event(sscs_pkg::CmdReset, 1'b0));
  endtask

  // one full pass at reset thresholds, with pressure extremes and failures
  task automatic test_directed_walk();
    sscs_pkg::in_beat_t ev;
    offer_event(make_event(sscs_pkg::CmdStart, 1'b1));
    ev = make_event(sscs_pkg::CmdExpiry, 1'b1);
    ev.mission_autonomous = 1'b0;                       // mission check fails, step holds
    offer_event(ev);
    walk_to(sscs_pkg::StepPneumatic);
    ev = make_event(sscs_pkg::CmdExpiry, 1'b1);
    ev.pneumatic_front = '1;                            // overpressure at full scale
    offer_event(ev);
    ev = make_event(sscs_pkg::CmdExpiry, 1'b1);
    ev.pneumatic_rear = '0;                             // empty rear tank
    offer_event(ev);
    offer_event(make_event(sscs_pkg::CmdExpiry, 1'b1)); // pass, waits for second start
    offer_event(make_event(sscs_pkg::CmdStart, 1'b1));
    offer_event(make_event(sscs_pkg::CmdStart, 1'b1));  // start in mid sequence is ignored
    walk_to(sscs_pkg::StepHydRelease);
    ev = make_event(sscs_pkg::CmdExpiry, 1'b1);
    ev.hydraulic_rear = '1;                             // brakes not released
    offer_event(ev);
    walk_to(sscs_pkg::StepSuccess);
    offer_event(make_event(sscs_pkg::CmdExpiry, 1'b1)); // success pulse, step stays
    offer_event(make_event(sscs_pkg::CmdReset, 1'b1));
    drain_results();
  endtask

  task automatic test_random_traffic(sscs_pkg::cfg_t t, int n_events, int idle_pct);
    load_thresholds(t);
    in_idle_pct  = idle_pct;
    out_idle_pct = idle_pct;
    repeat (n_events) offer_event(random_event());
    drain_results();
  endtask

  // receiver holds off for a long stretch while events keep coming, so the
  // block fills up and must stall its input
  task automatic test_backpressure();
    in_idle_pct = 0;
    hold_offs_asked++;
    repeat (40) offer_event(random_event());
    in_idle_pct = 30;
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus the long hold-off counted here
  // ---------------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_offs_served != hold_offs_asked) begin
        hold_offs_served++;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each accepted beat against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  always @(posedge clk) begin : check_outcome
    sscs_pkg::out_beat_t want;
    if (rst_ni === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result beat with no event pending");
      end else begin
        want = pending_outcomes.pop_front();
        check_field("timer_request", 8'(out_beat.timer_request), 8'(want.timer_request));
        check_field("actuator_command", 8'(out_beat.actuator_command),
                    8'(want.actuator_command));
        check_field("warning_code", 8'(out_beat.warning_code), 8'(want.warning_code));
        check_field("ebs_failure_led", 8'(out_beat.ebs_failure_led),
                    8'(want.ebs_failure_led));
        check_field("sequence_failed", 8'(out_beat.sequence_failed),
                    8'(want.sequence_failed));
        check_field("sequence_succeeded", 8'(out_beat.sequence_succeeded),
                    8'(want.sequence_succeeded));
        check_field("clear_brake_request", 8'(out_beat.clear_brake_request),
                    8'(want.clear_brake_request));
        check_field("current_step", 8'(out_beat.current_step), 8'(want.current_step));
      end
      results_seen++;
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni     <= 1'b0;
    in_valid   <= 1'b0;
    in_beat    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= sscs_pkg::RegHydReleaseMax;
    cfg_data   <= '0;
    seq_step    = sscs_pkg::StepIdle;
    thresholds  = {sscs_pkg::HydReleaseMaxRst, sscs_pkg::HydEngagedMinRst,
                   sscs_pkg::PneuOverPressRst, sscs_pkg::PneuMinPressRst};
    repeat (ResetCycles) @(posedge clk);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk);

    test_idle_events();
    test_directed_walk();
    // random walks under several threshold settings, one without any idling
    test_random_traffic(thresholds, 300, 30);
    test_random_traffic(plausible_thresholds(), 400, 0);
    test_random_traffic('0, 250, 30);
    test_random_traffic('1, 250, 30);
    test_random_traffic({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 300, 30);
    test_random_traffic(plausible_thresholds(), 300, 30);
    test_backpressure();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
